// ===== design/sdl_pkg.sv =====
// Shared types and constants for the symmetric difference list block.
// No dependencies; imported by symmetric_difference_lists (sdl_ram is generic).
package sdl_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = IDX_W + 1;
  localparam int ELEM_W     = 32;

  typedef enum logic [1:0] {
    OP_APPEND_A = 2'd0,
    OP_APPEND_B = 2'd1,
    OP_COMPARE  = 2'd2,
    OP_CLEAR    = 2'd3
  } sdl_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_RD,
    ST_KEY_LATCH,
    ST_SCAN,
    ST_EMIT,
    ST_FINISH
  } sdl_state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } sdl_in_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic               source_list;
    logic               element_valid;
    logic               last_result;
    logic               overflow_seen;
  } sdl_out_t;

endpackage

// ===== design/sdl_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
// Generic; no package dependencies.
module sdl_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/symmetric_difference_lists.sv =====
// Symmetric difference of two bounded lists: append, compare and clear items.
// Depends on sdl_pkg and two sdl_ram instances (one per list).
// Append and clear are taken in idle; a new item is taken every cycle while no compare runs.
// Compare: per source element the key is fetched (KEY_RD, KEY_LATCH), then the other
//   list is scanned until a match, an unmatched key is emitted (EMIT), and FINISH closes;
//   the single compare walk runs over the two RAM read ports, one list after the other.
//   Inputs stall while it runs.
// Reset (rst_n, sync, active low) empties both lists and the overflow bit; RAMs
//   are not cleared, entries past the counts are never used.
module symmetric_difference_lists
  import sdl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sdl_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output sdl_out_t out_item
);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  sdl_state_t state_r, state_nxt, adv_state;

  logic [CNT_W-1:0]  cnt_a_r, cnt_b_r;
  logic              ovf_r;
  logic              phase_r;       // 0: walking A against B, 1: B against A
  logic [IDX_W-1:0]  i_r;           // index into the source list
  logic [IDX_W-1:0]  j_r;           // index into the other list
  logic [ELEM_W-1:0] key_r;         // source element under test

  // one result held back so the final one can carry last_result
  logic              pend_v_r;
  logic [ELEM_W-1:0] pend_elem_r;
  logic              pend_src_r;

  logic              out_valid_r;
  sdl_out_t          out_item_r;

  // ---------------------------------------------------------------------------
  // RAMs
  // ---------------------------------------------------------------------------
  logic              we_a, we_b;
  logic [IDX_W-1:0]  waddr_a, waddr_b;
  logic [IDX_W-1:0]  addr_a, addr_b, scan_addr;
  logic [ELEM_W-1:0] rd_a, rd_b;

  sdl_ram #(.DEPTH(LIST_DEPTH), .WIDTH(ELEM_W), .AW(IDX_W)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (in_item.value),
    .raddr (addr_a),
    .rdata (rd_a)
  );

  sdl_ram #(.DEPTH(LIST_DEPTH), .WIDTH(ELEM_W), .AW(IDX_W)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (in_item.value),
    .raddr (addr_b),
    .rdata (rd_b)
  );

  // ---------------------------------------------------------------------------
  // Control decode
  // ---------------------------------------------------------------------------
  logic              in_take, is_cmp;
  logic [CNT_W-1:0]  src_cnt, oth_cnt;
  logic [ELEM_W-1:0] src_rdata, oth_rdata;
  logic              i_last, j_last, hit;
  logic              slot_free, emit_go, fin_go, adv_go, out_load;
  sdl_out_t          out_nxt;

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    in_take   = in_valid && !in_stall;
    is_cmp    = (sdl_op_t'(in_item.operation) == OP_COMPARE);

    src_cnt   = phase_r ? cnt_b_r : cnt_a_r;
    oth_cnt   = phase_r ? cnt_a_r : cnt_b_r;
    src_rdata = phase_r ? rd_b : rd_a;
    oth_rdata = phase_r ? rd_a : rd_b;

    // scan reads run one index ahead of the compare (registered RAM read data)
    scan_addr = (state_r == ST_SCAN) ? (j_r + IDX_W'(1)) : '0;
    addr_a    = phase_r ? scan_addr : i_r;
    addr_b    = phase_r ? i_r : scan_addr;

    // appends: RAM writes only happen in idle, compares only read, so no overlap
    we_a    = in_take && (sdl_op_t'(in_item.operation) == OP_APPEND_A)
              && (cnt_a_r < CNT_W'(LIST_DEPTH));
    we_b    = in_take && (sdl_op_t'(in_item.operation) == OP_APPEND_B)
              && (cnt_b_r < CNT_W'(LIST_DEPTH));
    waddr_a = cnt_a_r[IDX_W-1:0];
    waddr_b = cnt_b_r[IDX_W-1:0];

    i_last = (({1'b0, i_r} + CNT_W'(1)) == src_cnt);
    j_last = (({1'b0, j_r} + CNT_W'(1)) == oth_cnt);
    hit    = (oth_rdata == key_r);

    slot_free = !out_valid_r || !out_stall;
    emit_go   = (state_r == ST_EMIT) && (!pend_v_r || slot_free);
    fin_go    = (state_r == ST_FINISH) && slot_free;
    adv_go    = ((state_r == ST_SCAN) && hit) || emit_go;
    out_load  = (emit_go && pend_v_r) || fin_go;

    out_nxt.element       = signed'(pend_elem_r);
    out_nxt.source_list   = pend_src_r;
    out_nxt.element_valid = 1'b1;
    out_nxt.last_result   = fin_go;
    out_nxt.overflow_seen = ovf_r;
    if (fin_go && !pend_v_r) begin
      // nothing dissimilar: single marker result
      out_nxt.element       = '0;
      out_nxt.source_list   = 1'b0;
      out_nxt.element_valid = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    if (!i_last) begin
      adv_state = ST_KEY_RD;
    end else if (!phase_r && (cnt_b_r != '0)) begin
      adv_state = ST_KEY_RD;
    end else begin
      adv_state = ST_FINISH;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take && is_cmp) begin
          state_nxt = ((cnt_a_r != '0) || (cnt_b_r != '0)) ? ST_KEY_RD : ST_FINISH;
        end
      end
      ST_KEY_RD:    state_nxt = ST_KEY_LATCH;
      ST_KEY_LATCH: state_nxt = (oth_cnt == '0) ? ST_EMIT : ST_SCAN;
      ST_SCAN: begin
        if (hit) begin
          state_nxt = adv_state;
        end else if (j_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = adv_state;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      i_r         <= '0;
    end else begin
      state_r <= state_nxt;

      if (in_take) begin
        case (sdl_op_t'(in_item.operation))
          OP_APPEND_A: begin
            if (we_a) begin
              cnt_a_r <= cnt_a_r + CNT_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
          OP_APPEND_B: begin
            if (we_b) begin
              cnt_b_r <= cnt_b_r + CNT_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
          OP_CLEAR: begin
            cnt_a_r <= '0;
            cnt_b_r <= '0;
            ovf_r   <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      // walk position
      if (in_take && is_cmp) begin
        phase_r <= (cnt_a_r == '0);
        i_r     <= '0;
      end else if (adv_go) begin
        if (!i_last) begin
          i_r <= i_r + IDX_W'(1);
        end else if (!phase_r) begin
          phase_r <= 1'b1;
          i_r     <= '0;
        end
      end

      if (emit_go) begin
        pend_v_r <= 1'b1;
      end else if (fin_go) begin
        pend_v_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_KEY_LATCH) begin
      key_r <= src_rdata;
      j_r   <= '0;
    end else if (state_r == ST_SCAN) begin
      j_r <= j_r + IDX_W'(1);
    end
    if (emit_go) begin
      pend_elem_r <= key_r;
      pend_src_r  <= phase_r;
    end
    if (out_load) begin
      out_item_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_a_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= CNT_W'(LIST_DEPTH))
    else $error("list A count beyond depth");

  a_cnt_b_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_b_r <= CNT_W'(LIST_DEPTH))
    else $error("list B count beyond depth");

  a_lists_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> ($stable(cnt_a_r) && $stable(cnt_b_r) && $stable(ovf_r)))
    else $error("list state changed during compare");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("held result left over after compare");

  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> (out_valid_r && out_item_r.last_result && state_r == ST_IDLE))
    else $error("compare closed without a last result");

endmodule
